[hdl/idll_pkg.sv]
// Shared types, constants and the command microprograms of the linked list engine.
package idll_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int LINK_W = 10;
  localparam int STEP_W = 5;
  localparam logic [LINK_W-1:0] NO_LINK = '1;
  localparam logic [LINK_W-1:0] HEAD = '0;
  localparam logic [LINK_W-1:0] COUNT_MAX =
    LINK_W'((TABLE_ENTRIES - 2 < 1022) ? TABLE_ENTRIES - 2 : 1022);

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_REMOVE  = 3'd1;
  localparam logic [2:0] CMD_SWAP    = 3'd2;
  localparam logic [2:0] CMD_REVERSE = 3'd3;
  localparam logic [2:0] CMD_WALK    = 3'd4;

  localparam logic [1:0] SIDE_EMPTY = 2'd2;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  typedef enum logic [3:0] {
    PRG_NONE, PRG_INIT, PRG_INS_EMPTY, PRG_INS_AFTER, PRG_INS_BEFORE,
    PRG_REMOVE, PRG_SWAP, PRG_REVERSE, PRG_WALK
  } prog_t;

  typedef enum logic [1:0] {SC_A, SC_B, SC_C} swap_case_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_RN, OP_RP, OP_WN, OP_WP, OP_DECIDE, OP_WRD, OP_EMIT, OP_FLIP, OP_END
  } op_t;

  typedef enum logic [3:0] {
    SRC_I, SRC_J, SRC_HEAD, SRC_TAIL, SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_NONE
  } src_t;

  typedef struct packed {
    op_t        kind;
    src_t       a;
    src_t       d;
    logic [1:0] dst;
  } uop_t;

  function automatic uop_t mk(op_t k, src_t a, src_t d, logic [1:0] dst);
    uop_t u;
    u.kind = k;
    u.a    = a;
    u.d    = d;
    u.dst  = dst;
    return u;
  endfunction

  // One micro-op per step; a read lands in a temp one step later.
  function automatic uop_t uop(prog_t p, swap_case_t sc, logic [STEP_W-1:0] s);
    uop_t u;
    src_t x;
    src_t y;
    u = mk(OP_END, SRC_I, SRC_I, 2'd0);
    x = (sc == SC_B) ? SRC_J : SRC_I;
    y = (sc == SC_B) ? SRC_I : SRC_J;
    case (p)
      PRG_INIT: begin
        case (s)
          5'd0: u = mk(OP_WP, SRC_HEAD, SRC_NONE, 2'd0);
          5'd1: u = mk(OP_WN, SRC_HEAD, SRC_TAIL, 2'd0);
          5'd2: u = mk(OP_WP, SRC_TAIL, SRC_HEAD, 2'd0);
          5'd3: u = mk(OP_WN, SRC_TAIL, SRC_NONE, 2'd0);
          default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
        endcase
      end
      PRG_INS_EMPTY: begin
        case (s)
          5'd0: u = mk(OP_WP, SRC_I, SRC_HEAD, 2'd0);
          5'd1: u = mk(OP_WN, SRC_I, SRC_TAIL, 2'd0);
          5'd2: u = mk(OP_WN, SRC_HEAD, SRC_I, 2'd0);
          5'd3: u = mk(OP_WP, SRC_TAIL, SRC_I, 2'd0);
          default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
        endcase
      end
      PRG_INS_AFTER: begin
        case (s)
          5'd0: u = mk(OP_RN, SRC_J, SRC_I, 2'd0);
          5'd1: u = mk(OP_WP, SRC_T0, SRC_I, 2'd0);
          5'd2: u = mk(OP_WN, SRC_I, SRC_T0, 2'd0);
          5'd3: u = mk(OP_WP, SRC_I, SRC_J, 2'd0);
          5'd4: u = mk(OP_WN, SRC_J, SRC_I, 2'd0);
          default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
        endcase
      end
      PRG_INS_BEFORE: begin
        case (s)
          5'd0: u = mk(OP_RP, SRC_J, SRC_I, 2'd0);
          5'd1: u = mk(OP_WN, SRC_T0, SRC_I, 2'd0);
          5'd2: u = mk(OP_WP, SRC_I, SRC_T0, 2'd0);
          5'd3: u = mk(OP_WN, SRC_I, SRC_J, 2'd0);
          5'd4: u = mk(OP_WP, SRC_J, SRC_I, 2'd0);
          default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
        endcase
      end
      PRG_REMOVE: begin
        case (s)
          5'd0: u = mk(OP_RP, SRC_I, SRC_I, 2'd0);
          5'd1: u = mk(OP_RN, SRC_I, SRC_I, 2'd1);
          5'd2: u = mk(OP_WN, SRC_T0, SRC_T1, 2'd0);
          5'd3: u = mk(OP_RN, SRC_I, SRC_I, 2'd1);
          5'd4: u = mk(OP_WP, SRC_T1, SRC_T0, 2'd0);
          5'd5: u = mk(OP_WP, SRC_I, SRC_NONE, 2'd0);
          5'd6: u = mk(OP_WN, SRC_I, SRC_NONE, 2'd0);
          default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
        endcase
      end
      PRG_SWAP: begin
        if (s < 5'd3) begin
          case (s)
            5'd0: u = mk(OP_RN, SRC_I, SRC_I, 2'd0);
            5'd1: u = mk(OP_RN, SRC_J, SRC_I, 2'd1);
            default: u = mk(OP_DECIDE, SRC_I, SRC_I, 2'd0);
          endcase
        end else if (sc != SC_C) begin
          // adjacent pair: x directly precedes y
          case (s)
            5'd3:  u = mk(OP_RP, x, SRC_I, 2'd2);
            5'd4:  u = mk(OP_WN, SRC_T2, y, 2'd0);
            5'd5:  u = mk(OP_RN, y, SRC_I, 2'd3);
            5'd6:  u = mk(OP_WP, SRC_T3, x, 2'd0);
            5'd7:  u = mk(OP_RN, y, SRC_I, 2'd3);
            5'd8:  u = mk(OP_WN, x, SRC_T3, 2'd0);
            5'd9:  u = mk(OP_RP, x, SRC_I, 2'd2);
            5'd10: u = mk(OP_WP, y, SRC_T2, 2'd0);
            5'd11: u = mk(OP_WP, x, y, 2'd0);
            5'd12: u = mk(OP_WN, y, x, 2'd0);
            default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
          endcase
        end else begin
          case (s)
            5'd3:  u = mk(OP_RP, SRC_I, SRC_I, 2'd2);
            5'd4:  u = mk(OP_WN, SRC_T2, SRC_J, 2'd0);
            5'd5:  u = mk(OP_RN, SRC_I, SRC_I, 2'd3);
            5'd6:  u = mk(OP_WP, SRC_T3, SRC_J, 2'd0);
            5'd7:  u = mk(OP_RP, SRC_J, SRC_I, 2'd2);
            5'd8:  u = mk(OP_WN, SRC_T2, SRC_I, 2'd0);
            5'd9:  u = mk(OP_RN, SRC_J, SRC_I, 2'd3);
            5'd10: u = mk(OP_WP, SRC_T3, SRC_I, 2'd0);
            5'd11: u = mk(OP_RP, SRC_I, SRC_I, 2'd0);
            5'd12: u = mk(OP_RN, SRC_I, SRC_I, 2'd1);
            5'd13: u = mk(OP_RP, SRC_J, SRC_I, 2'd2);
            5'd14: u = mk(OP_WP, SRC_I, SRC_T2, 2'd0);
            5'd15: u = mk(OP_RN, SRC_J, SRC_I, 2'd3);
            5'd16: u = mk(OP_WN, SRC_I, SRC_T3, 2'd0);
            5'd17: u = mk(OP_WP, SRC_J, SRC_T0, 2'd0);
            5'd18: u = mk(OP_WN, SRC_J, SRC_T1, 2'd0);
            default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
          endcase
        end
      end
      PRG_REVERSE: begin
        case (s)
          5'd0: u = mk(OP_FLIP, SRC_I, SRC_I, 2'd0);
          default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
        endcase
      end
      PRG_WALK: begin
        case (s)
          5'd0: u = mk(OP_WRD, SRC_I, SRC_I, 2'd0);
          5'd1: u = mk(OP_EMIT, SRC_I, SRC_I, 2'd0);
          default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
        endcase
      end
      default: u = mk(OP_END, SRC_I, SRC_I, 2'd0);
    endcase
    return u;
  endfunction

endpackage

[hdl/idll_link_ram.sv]
// Simple dual-port link table with one write port and a registered read port.
module idll_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/indexed_doubly_linked_list_engine.sv]
// Commands run as microprograms, one micro-op per cycle on the link tables, except that a walk
//   step waits at its emit while the previous result is held by out_stall.
// Throughput: one command at a time; the next is taken in the idle cycle after the end.
// Reset (rst_n low, synchronous): item count 1022, orientation forward, cursor on head,
//   then a sentinel setup during which input is stalled; a count write repeats the same setup.
module indexed_doubly_linked_list_engine
  import idll_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_command,
  input  logic [LINK_W-1:0] in_item,
  input  logic [LINK_W-1:0] in_anchor,
  input  logic [1:0]        in_side,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [LINK_W-1:0] out_walk_item,
  output logic              out_walk_done,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LINK_W-1:0] cfg_item_count
);

  state_t            st_r, st_nxt;
  prog_t             prog_r;
  swap_case_t        sc_r;
  logic [STEP_W-1:0] step_r;
  logic [LINK_W-1:0] i_r, j_r;
  logic              restart_r;
  logic [LINK_W-1:0] tail_r;
  logic              orient_r;
  logic [LINK_W-1:0] cursor_r;
  logic              moved_r;
  logic [3:0][LINK_W-1:0] tmp_r;
  logic [3:0][LINK_W-1:0] tv;
  logic              pend_r;
  logic [1:0]        pdst_r;
  logic              ptab_r;
  logic              out_valid_r;
  logic [LINK_W-1:0] out_item_r;
  logic              out_done_r;

  uop_t              u;
  logic [LINK_W-1:0] a_val, d_val, rdata, next_q, prev_q, raddr;
  logic [LINK_W-1:0] far_end, new_cur, sat_count;
  logic              we_n, we_p, rd_issue, rd_tab, walk_moved;
  logic              in_acc, cfg_acc, hold, prog_end;

  idll_link_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(LINK_W)) u_next (
    .clk(clk), .we(we_n), .waddr(AW'(a_val)), .wdata(d_val),
    .raddr(AW'(raddr)), .rdata(next_q)
  );

  idll_link_ram #(.DEPTH(TABLE_ENTRIES), .WIDTH(LINK_W)) u_prev (
    .clk(clk), .we(we_p), .waddr(AW'(a_val)), .wdata(d_val),
    .raddr(AW'(raddr)), .rdata(prev_q)
  );

  assign u     = uop(prog_r, sc_r, step_r);
  assign rdata = ptab_r ? prev_q : next_q;

  // forward the read that lands this cycle
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tv[k] = (pend_r && pdst_r == 2'(k)) ? rdata : tmp_r[k];
    end
  end

  function automatic logic [LINK_W-1:0] pick(src_t s, logic [LINK_W-1:0] i,
      logic [LINK_W-1:0] j, logic [LINK_W-1:0] t, logic [3:0][LINK_W-1:0] v);
    logic [LINK_W-1:0] r;
    case (s)
      SRC_I:    r = i;
      SRC_J:    r = j;
      SRC_HEAD: r = HEAD;
      SRC_TAIL: r = t;
      SRC_T0:   r = v[0];
      SRC_T1:   r = v[1];
      SRC_T2:   r = v[2];
      SRC_T3:   r = v[3];
      default:  r = NO_LINK;
    endcase
    return r;
  endfunction

  assign a_val = pick(u.a, i_r, j_r, tail_r, tv);
  assign d_val = pick(u.d, i_r, j_r, tail_r, tv);

  assign far_end    = orient_r ? HEAD : tail_r;
  assign walk_moved = restart_r || (cursor_r != far_end);
  assign new_cur    = moved_r ? tv[0] : cursor_r;
  assign sat_count  = (cfg_item_count == '0) ? LINK_W'(1) :
                      (cfg_item_count > COUNT_MAX) ? COUNT_MAX : cfg_item_count;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (cfg_acc || in_acc) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (prog_end) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    cfg_ready = (st_r == ST_IDLE);
    in_stall  = (st_r != ST_IDLE) || cfg_valid;
    cfg_acc   = cfg_valid && cfg_ready;
    in_acc    = in_valid && !in_stall;
    we_n      = 1'b0;
    we_p      = 1'b0;
    rd_issue  = 1'b0;
    rd_tab    = 1'b0;
    raddr     = a_val;
    hold      = 1'b0;
    prog_end  = 1'b0;
    if (st_r == ST_RUN && rst_n) begin
      case (u.kind)
        OP_RN: rd_issue = 1'b1;
        OP_RP: begin
          rd_issue = 1'b1;
          rd_tab   = 1'b1;
        end
        OP_WN: we_n = 1'b1;
        OP_WP: we_p = 1'b1;
        OP_WRD: begin
          rd_issue = walk_moved;
          rd_tab   = orient_r;
          raddr    = restart_r ? (orient_r ? tail_r : HEAD) : cursor_r;
        end
        OP_EMIT: hold = out_valid_r && out_stall;
        OP_END:  prog_end = 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_walk_item = out_item_r;
  assign out_walk_done = out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      prog_r      <= PRG_INIT;
      step_r      <= '0;
      sc_r        <= SC_C;
      tail_r      <= COUNT_MAX + LINK_W'(1);
      orient_r    <= 1'b0;
      cursor_r    <= HEAD;
      moved_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= rd_issue;
      if (st_r == ST_RUN && u.kind == OP_EMIT && !hold) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_acc) begin
        tail_r   <= sat_count + LINK_W'(1);
        cursor_r <= HEAD;
        prog_r   <= PRG_INIT;
        step_r   <= '0;
      end else if (in_acc) begin
        step_r <= '0;
        case (in_command)
          CMD_INSERT: begin
            if (in_side == SIDE_EMPTY) begin
              prog_r <= PRG_INS_EMPTY;
            end else if (in_side[1]) begin
              prog_r <= PRG_NONE;
            end else if (in_side[0] == !orient_r) begin
              prog_r <= PRG_INS_AFTER;
            end else begin
              prog_r <= PRG_INS_BEFORE;
            end
          end
          CMD_REMOVE:  prog_r <= PRG_REMOVE;
          CMD_SWAP:    prog_r <= PRG_SWAP;
          CMD_REVERSE: prog_r <= PRG_REVERSE;
          CMD_WALK:    prog_r <= PRG_WALK;
          default:     prog_r <= PRG_NONE;
        endcase
      end else if (st_r == ST_RUN && !hold && !prog_end) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (st_r == ST_RUN) begin
        case (u.kind)
          OP_DECIDE: begin
            if (tv[0] == j_r) begin
              sc_r <= SC_A;
            end else if (tv[1] == i_r) begin
              sc_r <= SC_B;
            end else begin
              sc_r <= SC_C;
            end
          end
          OP_WRD:  moved_r <= walk_moved;
          OP_FLIP: orient_r <= !orient_r;
          OP_EMIT: begin
            if (!hold) begin
              cursor_r <= new_cur;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      i_r       <= in_item;
      j_r       <= in_anchor;
      restart_r <= in_restart;
    end
    if (rd_issue) begin
      pdst_r <= (u.kind == OP_WRD) ? 2'd0 : u.dst;
      ptab_r <= rd_tab;
    end
    if (pend_r) begin
      tmp_r[pdst_r] <= rdata;
    end
    if (st_r == ST_RUN && u.kind == OP_EMIT && !hold) begin
      out_item_r <= (new_cur == far_end) ? '0 : new_cur;
      out_done_r <= (new_cur == far_end);
    end
  end

`ifndef NO_ASSERTIONS
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN && u.kind == OP_END) |=> st_r == ST_IDLE)
    else $error("microprogram end did not return to idle");

  a_rose_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == ST_RUN && u.kind == OP_EMIT))
    else $error("result raised outside a walk emit");

  a_tail_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> (tail_r >= LINK_W'(2)))
    else $error("tail sentinel out of range");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_n && we_p))
    else $error("both link tables written in one cycle");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the indexed doubly linked list engine.
`timescale 1ns / 100ps

module tb_top
  import idll_pkg::*;
();

  localparam int LIMIT_CYCLES = 900000;
  localparam int SETTLE = 25;

  typedef struct {
    logic [LINK_W-1:0] nxt[TABLE_ENTRIES];
    logic [LINK_W-1:0] prv[TABLE_ENTRIES];
    bit                wn[TABLE_ENTRIES];
    bit                wp[TABLE_ENTRIES];
    bit                backward;
    logic [LINK_W-1:0] cursor;
    logic [LINK_W-1:0] count;
  } list_state_t;

  typedef struct {
    logic [2:0]        command;
    logic [LINK_W-1:0] item;
    logic [LINK_W-1:0] anchor;
    logic [1:0]        side;
    logic              restart;
    int                gap;
  } list_cmd_t;

  typedef struct {
    logic [LINK_W-1:0] walk_item;
    logic              walk_done;
  } walk_step_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_command = CMD_WALK;
  logic [LINK_W-1:0] in_item = '0;
  logic [LINK_W-1:0] in_anchor = '0;
  logic [1:0]        in_side = '0;
  logic              in_restart = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [LINK_W-1:0] out_walk_item;
  logic              out_walk_done;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LINK_W-1:0] cfg_item_count = '0;

  indexed_doubly_linked_list_engine uut (.*);

  always #2 clk = ~clk;

  list_state_t live_list, plan_list, trial_list;
  list_cmd_t   pending_cmds[$];
  walk_step_t  walk_expect[$];
  bit          member[TABLE_ENTRIES];
  int          members[$];
  int          errors = 0;
  int          cycles = 0;
  int          walks_checked = 0;
  int          cmds_sent = 0;
  int          walks_planned = 0;
  bit          burst_mode = 1'b0;

  function automatic logic [LINK_W-1:0] rd_n(ref list_state_t s, input logic [LINK_W-1:0] a,
                                             ref bit bad);
    if (!s.wn[a]) bad = 1'b1;
    return s.nxt[a];
  endfunction

  function automatic logic [LINK_W-1:0] rd_p(ref list_state_t s, input logic [LINK_W-1:0] a,
                                             ref bit bad);
    if (!s.wp[a]) bad = 1'b1;
    return s.prv[a];
  endfunction

  function automatic void wr_n(ref list_state_t s, input logic [LINK_W-1:0] a,
                               input logic [LINK_W-1:0] v);
    s.nxt[a] = v;
    s.wn[a] = 1'b1;
  endfunction

  function automatic void wr_p(ref list_state_t s, input logic [LINK_W-1:0] a,
                               input logic [LINK_W-1:0] v);
    s.prv[a] = v;
    s.wp[a] = 1'b1;
  endfunction

  function automatic void load_count(ref list_state_t s, input logic [LINK_W-1:0] v);
    logic [LINK_W-1:0] t;
    s.count = (v < 1) ? LINK_W'(1) : (v > COUNT_MAX) ? COUNT_MAX : v;
    t = s.count + 1'b1;
    wr_p(s, HEAD, NO_LINK);
    wr_n(s, HEAD, t);
    wr_p(s, t, HEAD);
    wr_n(s, t, NO_LINK);
    s.cursor = HEAD;
  endfunction

  // Apply one command; flag any read of a never-written table entry.
  function automatic void apply_cmd(ref list_state_t s, input list_cmd_t c, output bit has_walk,
                                    output walk_step_t w, output bit bad);
    logic [LINK_W-1:0] i, j, t, far_end, tp, tn;
    bit fwd;
    i = c.item;
    j = c.anchor;
    t = s.count + 1'b1;
    fwd = !s.backward;
    bad = 1'b0;
    has_walk = 1'b0;
    w.walk_item = '0;
    w.walk_done = 1'b0;
    case (c.command)
      CMD_INSERT: begin
        if (c.side == SIDE_EMPTY) begin
          wr_p(s, i, HEAD);
          wr_n(s, i, t);
          wr_n(s, HEAD, i);
          wr_p(s, t, i);
        end else if (c.side < SIDE_EMPTY) begin
          if ((c.side == 2'd1) == fwd) begin
            wr_p(s, rd_n(s, j, bad), i);
            wr_n(s, i, rd_n(s, j, bad));
            wr_p(s, i, j);
            wr_n(s, j, i);
          end else begin
            wr_n(s, rd_p(s, j, bad), i);
            wr_p(s, i, rd_p(s, j, bad));
            wr_n(s, i, j);
            wr_p(s, j, i);
          end
        end
      end
      CMD_REMOVE: begin
        wr_n(s, rd_p(s, i, bad), rd_n(s, i, bad));
        wr_p(s, rd_n(s, i, bad), rd_p(s, i, bad));
        wr_p(s, i, NO_LINK);
        wr_n(s, i, NO_LINK);
      end
      CMD_SWAP: begin
        if (rd_n(s, i, bad) == j) begin
          wr_n(s, rd_p(s, i, bad), j);
          wr_p(s, rd_n(s, j, bad), i);
          wr_n(s, i, rd_n(s, j, bad));
          wr_p(s, j, rd_p(s, i, bad));
          wr_p(s, i, j);
          wr_n(s, j, i);
        end else if (rd_n(s, j, bad) == i) begin
          wr_n(s, rd_p(s, j, bad), i);
          wr_p(s, rd_n(s, i, bad), j);
          wr_n(s, j, rd_n(s, i, bad));
          wr_p(s, i, rd_p(s, j, bad));
          wr_p(s, j, i);
          wr_n(s, i, j);
        end else begin
          wr_n(s, rd_p(s, i, bad), j);
          wr_p(s, rd_n(s, i, bad), j);
          wr_n(s, rd_p(s, j, bad), i);
          wr_p(s, rd_n(s, j, bad), i);
          tp = rd_p(s, i, bad);
          tn = rd_n(s, i, bad);
          wr_p(s, i, rd_p(s, j, bad));
          wr_n(s, i, rd_n(s, j, bad));
          wr_p(s, j, tp);
          wr_n(s, j, tn);
        end
      end
      CMD_REVERSE: s.backward = !s.backward;
      CMD_WALK: begin
        far_end = fwd ? t : HEAD;
        if (c.restart) s.cursor = fwd ? rd_n(s, HEAD, bad) : rd_p(s, t, bad);
        else if (s.cursor != far_end)
          s.cursor = fwd ? rd_n(s, s.cursor, bad) : rd_p(s, s.cursor, bad);
        has_walk = 1'b1;
        if (s.cursor == far_end) w.walk_done = 1'b1;
        else w.walk_item = s.cursor;
      end
      default: ;
    endcase
  endfunction

  function automatic void drop_member(int v);
    member[v] = 1'b0;
    foreach (members[k]) if (members[k] == v) begin
      members.delete(k);
      break;
    end
  endfunction

  // Queue a command if it stays within written entries; track membership when well formed.
  function automatic bit plan_cmd(logic [2:0] c, logic [LINK_W-1:0] i, logic [LINK_W-1:0] j,
                                  logic [1:0] sd, logic rs, bit well_formed);
    list_cmd_t  lc;
    walk_step_t w;
    bit         hw, bad;
    lc.command = c;
    lc.item = i;
    lc.anchor = j;
    lc.side = sd;
    lc.restart = rs;
    lc.gap = burst_mode ? 0 : $urandom_range(0, 12);
    trial_list = plan_list;
    apply_cmd(trial_list, lc, hw, w, bad);
    if (bad) return 1'b0;
    plan_list = trial_list;
    pending_cmds.push_back(lc);
    if (hw) walks_planned++;
    if (well_formed && c == CMD_INSERT) begin
      member[i] = 1'b1;
      members.push_back(int'(i));
    end
    if (well_formed && c == CMD_REMOVE) drop_member(int'(i));
    return 1'b1;
  endfunction

  function automatic int pick_free();
    int v;
    do v = $urandom_range(1, plan_list.count); while (member[v]);
    return v;
  endfunction

  function automatic void plan_random();
    int  r, a, b;
    bit  ok;
    ok = 1'b0;
    while (!ok) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        ok = plan_cmd(3'($urandom_range(0, 7)), LINK_W'($urandom), LINK_W'($urandom),
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0);
      end else if (members.size() == 0) begin
        ok = plan_cmd(CMD_INSERT, LINK_W'(pick_free()), '0, SIDE_EMPTY, 1'b0, 1'b1);
      end else if (r < 36 && members.size() < plan_list.count) begin
        ok = plan_cmd(CMD_INSERT, LINK_W'(pick_free()),
                      LINK_W'(members[$urandom_range(0, members.size() - 1)]),
                      2'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
      end else if (r < 50) begin
        ok = plan_cmd(CMD_REMOVE, LINK_W'(members[$urandom_range(0, members.size() - 1)]), '0,
                      2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b1);
      end else if (r < 62 && members.size() > 1) begin
        a = $urandom_range(0, members.size() - 1);
        do b = $urandom_range(0, members.size() - 1); while (b == a);
        ok = plan_cmd(CMD_SWAP, LINK_W'(members[a]), LINK_W'(members[b]),
                      2'($urandom_range(0, 3)), 1'b0, 1'b1);
      end else if (r < 70) begin
        ok = plan_cmd(CMD_REVERSE, LINK_W'($urandom), LINK_W'($urandom),
                      2'($urandom_range(0, 3)), 1'b0, 1'b1);
      end else begin
        ok = plan_cmd(CMD_WALK, LINK_W'($urandom), LINK_W'($urandom), 2'($urandom_range(0, 3)),
                      $urandom_range(0, 5) == 0, 1'b1);
      end
    end
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || walk_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(logic [LINK_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_item_count <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    load_count(live_list, v);
    load_count(plan_list, v);
    foreach (member[k]) member[k] = 1'b0;
    members.delete();
  endtask

  task automatic plan_phase(int n);
    repeat (n) begin
      if ($urandom_range(0, 149) == 0) burst_mode = !burst_mode;
      plan_random();
    end
  endtask

  // Driver: offer queued transactions with per-item gaps; predict at acceptance.
  int          gap_left = 0;
  list_cmd_t   offered;
  always @(posedge clk) begin
    bit         busy;
    bit         hw, bad;
    walk_step_t w;
    if (rst_n) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        apply_cmd(live_list, offered, hw, w, bad);
        if (hw) walk_expect.push_back(w);
        cmds_sent++;
        gap_left = offered.gap;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) gap_left--;
        else if (pending_cmds.size() != 0) begin
          offered = pending_cmds.pop_front();
          in_command <= offered.command;
          in_item <= offered.item;
          in_anchor <= offered.anchor;
          in_side <= offered.side;
          in_restart <= offered.restart;
          busy = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  // Monitor: check walk results in order; stall at random, once for a long stretch.
  int stall_left = 0;
  bit long_hold_done = 1'b0;
  bit stall_burst = 1'b0;
  always @(posedge clk) begin
    walk_step_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (walk_expect.size() == 0) begin
          $display("%0t: unexpected walk result item=%0d done=%0b", $time, out_walk_item,
                   out_walk_done);
          errors++;
        end else begin
          w = walk_expect.pop_front();
          if (out_walk_item !== w.walk_item) begin
            $display("%0t: walk_item expected %0d actual %0d", $time, w.walk_item,
                     out_walk_item);
            errors++;
          end
          if (out_walk_done !== w.walk_done) begin
            $display("%0t: walk_done expected %0b actual %0b", $time, w.walk_done,
                     out_walk_done);
            errors++;
          end
        end
        walks_checked++;
        if (walks_checked % 64 == 0) stall_burst = !stall_burst;
        if (!long_hold_done && walks_checked == 150) begin
          stall_left = 400;
          long_hold_done = 1'b1;
        end else stall_left = stall_burst ? 0 : $urandom_range(0, 12);
      end else if (stall_left > 0) stall_left--;
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("indexed_doubly_linked_list_engine: mismatch");
      $finish;
    end
  end

  initial begin
    bit                ok;
    logic [LINK_W-1:0] counts[6];
    counts = '{10'd1, 10'd1023, 10'd0, 10'd7, 10'd1022, 10'd64};
    load_count(live_list, COUNT_MAX);
    live_list.backward = 1'b0;
    plan_list = live_list;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: walks from reset in both orientations, all inserts, every swap shape.
    ok = plan_cmd(CMD_WALK, '0, '0, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_REVERSE, '0, '0, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_WALK, '0, '0, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_WALK, '0, '0, '0, 1'b1, 1'b1);
    ok = plan_cmd(CMD_REVERSE, '0, '0, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_INSERT, 10'd1, '0, SIDE_EMPTY, 1'b0, 1'b1);
    ok = plan_cmd(CMD_INSERT, COUNT_MAX, 10'd1, 2'd1, 1'b0, 1'b1);
    ok = plan_cmd(CMD_INSERT, 10'd500, 10'd1, 2'd0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_WALK, '0, '0, '0, 1'b1, 1'b1);
    repeat (4) ok = plan_cmd(CMD_WALK, '0, '0, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_SWAP, 10'd1, COUNT_MAX, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_SWAP, 10'd1, COUNT_MAX, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_SWAP, 10'd500, COUNT_MAX, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_REVERSE, '0, '0, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_INSERT, 10'd7, 10'd1, 2'd1, 1'b0, 1'b1);
    ok = plan_cmd(CMD_WALK, '0, '0, '0, 1'b1, 1'b1);
    repeat (3) ok = plan_cmd(CMD_WALK, '0, '0, '0, 1'b0, 1'b1);
    ok = plan_cmd(CMD_REMOVE, 10'd1, '0, '0, 1'b0, 1'b1);
    ok = plan_cmd(3'd5, '1, '1, 2'd3, 1'b1, 1'b0);
    ok = plan_cmd(3'd6, '0, '0, '0, 1'b0, 1'b0);
    ok = plan_cmd(3'd7, '1, '1, 2'd3, 1'b1, 1'b0);
    ok = plan_cmd(CMD_INSERT, 10'd9, 10'd7, 2'd3, 1'b0, 1'b0);
    ok = plan_cmd(CMD_WALK, '0, '0, '0, 1'b1, 1'b1);
    plan_phase(400);
    wait_drained();
    foreach (counts[k]) begin
      write_count(counts[k]);
      plan_phase(220);
      wait_drained();
    end
    $display("ran %0d commands through seven item counts, checked %0d walk steps", cmds_sent,
             walks_checked);
    if (errors == 0) $display("indexed_doubly_linked_list_engine: match");
    else $display("indexed_doubly_linked_list_engine: mismatch");
    $finish;
  end

endmodule
